[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the image word CRC-32 checker.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge while out of reset.
`define IWCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true while out of reset.
`define IWCC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/iwcc_pkg.sv]
// Package for the image word CRC-32 checker: constants, types and the
// elaboration-time builder of the CRC shift matrices. Depends on nothing.
`timescale 1ns / 1ps

package iwcc_pkg;

    localparam int unsigned CRC_W     = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STEPS     = 32;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

    // One column per register bit: the image of that bit after a number of shift steps.
    typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

    // Builds the matrix of a run of MSB-first shift steps. Used on constants only.
    function automatic crc_mat_t build_mat(input int unsigned steps);
        crc_mat_t    mat;
        logic [CRC_W-1:0] v;
        for (int j = 0; j < CRC_W; j++) begin
            v = '0;
            v[j] = 1'b1;
            for (int unsigned k = 0; k < steps; k++) begin
                if (v[CRC_W-1]) begin
                    v = (v << 1) ^ CRC_POLY;
                end else begin
                    v = v << 1;
                end
            end
            mat[j] = v;
        end
        return mat;
    endfunction

    // Folding one byte runs the register through one block of steps.
    localparam crc_mat_t MAT_ONE = build_mat(STEPS);
    localparam crc_mat_t MAT_TWO = build_mat(2 * STEPS);

    // Load request from the CRC stage into the output register.
    typedef struct packed {
        logic             load;
        logic [CRC_W-1:0] crc;
        logic             match;
    } iwcc_result_t;

endpackage

[rtl/core/iwcc_fold.sv]
// XOR network that folds one 16-bit data word, low byte first, into the CRC.
// Depends on iwcc_pkg for the shift matrices.
`timescale 1ns / 1ps

module iwcc_fold (
    input  logic [iwcc_pkg::CRC_W-1:0]  crc_in,
    input  logic [iwcc_pkg::BYTE_W-1:0] data_low,
    input  logic [iwcc_pkg::BYTE_W-1:0] data_high,
    output logic [iwcc_pkg::CRC_W-1:0]  crc_out
);

    // The steps are linear: the register and the low byte pass through both byte
    // blocks, the high byte through the second one only.
    always_comb begin
        crc_out = '0;
        for (int i = 0; i < iwcc_pkg::CRC_W; i++) begin
            if (crc_in[i]) begin
                crc_out = crc_out ^ iwcc_pkg::MAT_TWO[i];
            end
        end
        for (int i = 0; i < iwcc_pkg::BYTE_W; i++) begin
            if (data_low[i]) begin
                crc_out = crc_out ^ iwcc_pkg::MAT_TWO[i];
            end
            if (data_high[i]) begin
                crc_out = crc_out ^ iwcc_pkg::MAT_ONE[i];
            end
        end
    end

endmodule

[rtl/core/iwcc_out_reg.sv]
// Result register of the image word CRC-32 checker, holding one transaction
// for the master-side stream. Depends on iwcc_pkg.
`timescale 1ns / 1ps

module iwcc_out_reg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  iwcc_pkg::iwcc_result_t     result,
    output logic                       out_free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [iwcc_pkg::CRC_W-1:0] m_tdata,   // [31:0] crc_value
    output logic                       m_tuser    // [0] crc_match
);

    logic                       valid_reg, valid_next;
    logic [iwcc_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic                       match_reg, match_next;

    // The register can take a new result when empty or when drained this cycle.
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        crc_next   = crc_reg;
        match_next = match_reg;
        if (result.load) begin
            valid_next = 1'b1;
            crc_next   = result.crc;
            match_next = result.match;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        crc_reg   <= crc_next;
        match_reg <= match_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = crc_reg;
    assign m_tuser  = match_reg;

endmodule

[rtl/core/image_word_crc32_checker.sv]
// Top level of the image word CRC-32 checker: input register, running CRC and
// expected-value register. Depends on iwcc_pkg, iwcc_fold and iwcc_out_reg.
`timescale 1ns / 1ps
//
// Usage:
// Each slave-side transaction carries one 16-bit data word of an image, low
// byte in s_tdata[7:0], high byte in s_tdata[15:8]; s_tlast marks the final
// word. Every word is folded into a running CRC-32 (polynomial 04C11DB7,
// 32 shift steps per byte). The word with s_tlast set produces one
// master-side transaction: the final CRC on m_tdata and, on m_tuser, whether
// it equals the expected CRC. Words without s_tlast produce nothing.
// The expected CRC is written through the cfg_valid / cfg_ready / cfg_data
// channel while the block is idle; cfg_ready is always high.
// A last word is held in the input register, then loads the output register,
// which sets m_tvalid. One word is taken every cycle while no last word waits;
// the whole fold is one XOR network between the input and CRC registers.
// Reset (aresetn low, synchronous) empties both registers, sets the running
// CRC to all ones and the expected CRC to zero. When the receiver stalls, the
// result waits in the output register while words without s_tlast keep
// flowing; a last word waits in the input register until the output frees.
//
`include "assert_macros.svh"

module image_word_crc32_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [iwcc_pkg::CRC_W-1:0] cfg_data,   // [31:0] expected_crc
    // Slave-side stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,    // [7:0] data_low, [15:8] data_high
    input  logic                       s_tlast,
    // Master-side stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [iwcc_pkg::CRC_W-1:0] m_tdata,    // [31:0] crc_value
    output logic                       m_tuser     // [0] crc_match
);

    logic                        in_valid_reg, in_valid_next;
    logic [iwcc_pkg::BYTE_W-1:0] low_reg, low_next;
    logic [iwcc_pkg::BYTE_W-1:0] high_reg, high_next;
    logic                        last_reg, last_next;
    logic [iwcc_pkg::CRC_W-1:0]  crc_reg, crc_next;
    logic [iwcc_pkg::CRC_W-1:0]  expected_reg, expected_next;
    logic [iwcc_pkg::CRC_W-1:0]  crc_folded;
    logic                        out_free;
    logic                        advance;
    iwcc_pkg::iwcc_result_t      result;

    assign cfg_ready = 1'b1;

    // The held word moves on unless it is a last word facing a full output.
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    iwcc_fold u_fold (
        .crc_in    (crc_reg),
        .data_low  (low_reg),
        .data_high (high_reg),
        .crc_out   (crc_folded)
    );

    // Result handed to the output register on a last word.
    always_comb begin
        result.load  = advance && last_reg;
        result.crc   = crc_folded;
        result.match = (crc_folded == expected_reg);
    end

    iwcc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Input register, running CRC and expected CRC.
    always_comb begin
        in_valid_next = in_valid_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        last_next     = last_reg;
        crc_next      = crc_reg;
        expected_next = expected_reg;
        if (advance) begin
            in_valid_next = 1'b0;
            crc_next      = last_reg ? iwcc_pkg::CRC_INIT : crc_folded;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            low_next      = s_tdata[7:0];
            high_next     = s_tdata[15:8];
            last_next     = s_tlast;
        end
        if (cfg_valid && cfg_ready) begin
            expected_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            crc_reg      <= iwcc_pkg::CRC_INIT;
            expected_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            crc_reg      <= crc_next;
            expected_reg <= expected_next;
        end
        low_reg  <= low_next;
        high_reg <= high_next;
        last_reg <= last_next;
    end

    // A finished image always shows up at the output in the next cycle.
    `IWCC_ASSERT(a_result_loaded, aclk, aresetn, (advance && last_reg) |=> m_tvalid, "last word did not load the result")
    // The running CRC restarts after each image.
    `IWCC_ASSERT(a_crc_restart, aclk, aresetn, (advance && last_reg) |=> (crc_reg == iwcc_pkg::CRC_INIT), "running CRC not restarted")
    // A blocked last word stays held with its CRC state untouched.
    `IWCC_ASSERT(a_last_held, aclk, aresetn, (in_valid_reg && last_reg && !out_free) |=> (in_valid_reg && last_reg && $stable(crc_reg)), "blocked last word lost")
    // The output never takes a new result while it still holds an untaken one.
    `IWCC_NEVER(a_no_overwrite, aclk, aresetn, result.load && m_tvalid && !m_tready, "result overwritten before transfer")

endmodule
